FILE: rtl/base79_integer_encoder_assert.svh
// Assertion macros used by the base-79 encoder checker
`ifndef BASE79_INTEGER_ENCODER_ASSERT_SVH
`define BASE79_INTEGER_ENCODER_ASSERT_SVH

// same-cycle implication, off during reset
`define BENC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BENC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always on
`define BENC_ASSERT_ALW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/benc_pkg.sv
// Shared constants and types of the base-79 encoder
`timescale 1ns / 1ps
`default_nettype none
package benc_pkg;
    localparam int unsigned VALUE_W         = 64;
    localparam int unsigned DIGIT_W         = 7;
    localparam int unsigned OUT_W           = 8;
    localparam int unsigned CNT_W           = 4;
    localparam int unsigned MAX_DIGITS      = 11;
    localparam int unsigned CHUNK_W         = 8;
    localparam int unsigned CHUNKS          = VALUE_W / CHUNK_W;
    localparam int unsigned CHUNK_CNT_W     = $clog2(CHUNKS);
    localparam int unsigned RADIX           = 79;
    localparam logic [DIGIT_W-1:0] CHAR_BASE = 7'd48;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic               wr_en;
        logic [CNT_W-1:0]   wr_idx;
        logic [DIGIT_W-1:0] wr_char;
        logic               push;
        logic [CNT_W-1:0]   len;
    } t_wr;

    typedef struct packed {
        logic [CNT_W-1:0] idx;
        logic             pop;
    } t_req;

    typedef struct packed {
        logic               avail;
        logic [CNT_W-1:0]   len;
        logic [DIGIT_W-1:0] rd_char;
    } t_rd;
endpackage
`default_nettype wire

FILE: rtl/benc_front.sv
// Front end: accepts a number and divides it by 79 one byte per cycle
`timescale 1ns / 1ps
`default_nettype none
module benc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [benc_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_full,
    output benc_pkg::t_wr               o_wr
);
    import benc_pkg::*;

    typedef enum logic {S_IDLE, S_DIV} t_state;

    t_state                 r_state;
    logic [VALUE_W-1:0]     r_work;
    logic [DIGIT_W-1:0]     r_rem;
    logic [CHUNK_CNT_W-1:0] r_chunk;
    logic [CNT_W-1:0]       r_n;
    logic                   r_nz;

    logic [CHUNK_W-1:0]     n_quo;
    logic [DIGIT_W-1:0]     n_rem;
    logic                   n_nz;
    logic                   last_chunk;

    always_comb begin
        logic [DIGIT_W:0]   v_x;
        logic [CHUNK_W-1:0] v_byte;
        v_byte = r_work[VALUE_W-1 -: CHUNK_W];
        v_x    = {1'b0, r_rem};
        n_quo  = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            v_x = {v_x[DIGIT_W-1:0], v_byte[i]};
            if (v_x >= (DIGIT_W+1)'(RADIX)) begin
                v_x      = v_x - (DIGIT_W+1)'(RADIX);
                n_quo[i] = 1'b1;
            end
        end
        n_rem = v_x[DIGIT_W-1:0];
    end

    assign n_nz       = r_nz | (n_quo != '0);
    assign last_chunk = (r_state == S_DIV) && (r_chunk == '0);
    assign o_s_tready = (r_state == S_IDLE) && !i_full;

    assign o_wr.wr_en   = last_chunk;
    assign o_wr.wr_idx  = r_n;
    assign o_wr.wr_char = n_rem + CHAR_BASE;
    assign o_wr.push    = last_chunk && !n_nz;
    assign o_wr.len     = r_n + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        r_work  <= i_value;
                        r_rem   <= '0;
                        r_chunk <= CHUNK_CNT_W'(CHUNKS - 1);
                        r_n     <= '0;
                        r_nz    <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_work <= {r_work[VALUE_W-CHUNK_W-1:0], n_quo};
                    if (r_chunk == '0) begin
                        r_rem   <= '0;
                        r_nz    <= 1'b0;
                        r_chunk <= CHUNK_CNT_W'(CHUNKS - 1);
                        r_n     <= r_n + CNT_W'(1);
                        if (!n_nz) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_rem   <= n_rem;
                        r_nz    <= n_nz;
                        r_chunk <= r_chunk - CHUNK_CNT_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/benc_queue.sv
// Digit buffer queue between the divider and the character emitter
`timescale 1ns / 1ps
`default_nettype none
module benc_queue #(
    parameter int unsigned QUEUE_DEPTH = benc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  benc_pkg::t_wr  i_wr,
    output logic           o_full,
    input  benc_pkg::t_req i_req,
    output benc_pkg::t_rd  o_rd
);
    import benc_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [DIGIT_W-1:0] r_dig [QUEUE_DEPTH][MAX_DIGITS];
    logic [CNT_W-1:0]   r_len [QUEUE_DEPTH];
    logic [PW-1:0]      r_wptr;
    logic [PW-1:0]      r_rptr;
    logic [CW-1:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_dig[r_wptr][i_wr.wr_idx] <= i_wr.wr_char;
        end
        if (i_wr.push) begin
            r_len[r_wptr] <= i_wr.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_req.pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({i_wr.push, i_req.pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full        = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_rd.avail    = (r_cnt != '0);
    assign o_rd.len      = r_len[r_rptr];
    assign o_rd.rd_char  = r_dig[r_rptr][i_req.idx];
endmodule
`default_nettype wire

FILE: rtl/benc_back.sv
// Back end: sends buffered digits most significant first through an output register
`timescale 1ns / 1ps
`default_nettype none
module benc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  benc_pkg::t_rd                i_rd,
    output benc_pkg::t_req               o_req,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [benc_pkg::DIGIT_W-1:0] o_char,
    output logic                         o_last
);
    import benc_pkg::*;

    logic [CNT_W-1:0]   r_k;
    logic               r_ovalid;
    logic [DIGIT_W-1:0] r_char;
    logic               r_last;

    logic               load;
    logic               is_last;

    assign load      = i_rd.avail && (!r_ovalid || i_m_tready);
    assign is_last   = (r_k == i_rd.len - CNT_W'(1));
    assign o_req.idx = i_rd.len - CNT_W'(1) - r_k;
    assign o_req.pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_rd.rd_char;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_k      <= is_last ? '0 : r_k + CNT_W'(1);
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_char     = r_char;
    assign o_last     = r_last;
endmodule
`default_nettype wire

FILE: rtl/base79_integer_encoder.sv
// Base-79 encoder: 64-bit unsigned number in, ASCII digit characters out
// Each digit comes from the byte-wise divider (8 restoring steps a cycle); a number
// of 1..11 digits holds the front end until its last digit is queued. The first char
// is then registered; the rest follow one a cycle while m_axis_tready stays high.
// The digit queue lets the next number divide while earlier characters drain.
// Synchronous active-low reset empties the queue and clears the output valid.
`timescale 1ns / 1ps
`default_nettype none
module base79_integer_encoder #(
    parameter int unsigned QUEUE_DEPTH = benc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [benc_pkg::VALUE_W-1:0]  s_axis_tdata,  // [63:0] value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [benc_pkg::OUT_W-1:0]    m_axis_tdata,  // [6:0] digit_char, [7] zero
    output logic                          m_axis_tlast   // last_digit
);
    import benc_pkg::*;

    t_wr                wr;
    t_req               req;
    t_rd                rd;
    logic               full;
    logic [DIGIT_W-1:0] out_char;

    benc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_value    (s_axis_tdata),
        .i_full     (full),
        .o_wr       (wr)
    );

    benc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .i_req   (req),
        .o_rd    (rd)
    );

    benc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (rd),
        .o_req      (req),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_char     (out_char),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_W - DIGIT_W){1'b0}}, out_char};
endmodule
`default_nettype wire

FILE: rtl/benc_checker.sv
// Port-level checker for the base-79 encoder and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "base79_integer_encoder_assert.svh"
module benc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [benc_pkg::OUT_W-1:0]   m_axis_tdata,
    input logic                         m_axis_tlast
);
    import benc_pkg::*;

    logic r_first;
    logic m_hs;
    logic s_hs;

    assign m_hs = m_axis_tvalid && m_axis_tready;
    assign s_hs = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (m_hs) begin
            r_first <= m_axis_tlast;
        end
    end

    `BENC_ASSERT_ALW(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")
    `BENC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled item changed")
    `BENC_ASSERT_IMP(a_char_range, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[7] == 1'b0) && (m_axis_tdata[6:0] >= CHAR_BASE) && (m_axis_tdata[6:0] <= CHAR_BASE + 7'd78), "character out of range")
    `BENC_ASSERT_IMP(a_no_lead_zero, i_clk, i_rst_n, m_hs && r_first && (m_axis_tdata[6:0] == CHAR_BASE), m_axis_tlast, "leading zero digit")
    `BENC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_hs, !s_axis_tready, "input ready right after accept")
endmodule

bind base79_integer_encoder benc_checker u_checker (.*);
`default_nettype wire
